>>> design/vpts_pkg.sv
package vpts_pkg;

    localparam int unsigned CoefW  = 16;
    localparam int unsigned AccW   = 34;
    localparam int unsigned MagW   = 33;
    localparam int unsigned NumW   = MagW + 16;
    localparam int unsigned NdcW   = 35;
    localparam int unsigned ProdW  = NdcW + 14;

    localparam logic [2:0] REG_ROW0   = 3'd0;
    localparam logic [2:0] REG_ROW1   = 3'd1;
    localparam logic [2:0] REG_ROW2   = 3'd2;
    localparam logic [2:0] REG_ROW3   = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [63:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [63:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [63:0] ROW3_RESET = 64'h1000_0000_0000_0000;
    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic signed [15:0] vert_x;
        logic signed [15:0] vert_y;
        logic signed [15:0] vert_z;
    } t_in;

    typedef struct packed {
        logic signed [19:0] screen_x;
        logic signed [19:0] screen_y;
        logic signed [15:0] depth_z;
        logic signed [31:0] clip_w;
        logic               divided;
    } t_out;

    typedef struct packed {
        logic                   div;
        logic signed [AccW-1:0] ax;
        logic signed [AccW-1:0] ay;
        logic signed [AccW-1:0] az;
        logic signed [AccW-1:0] aw;
    } t_side;

    function automatic logic signed [19:0] sat20(input logic signed [ProdW:0] v);
        if (v > $signed((ProdW+1)'(524287))) begin
            return 20'sh7FFFF;
        end else if (v < -$signed((ProdW+1)'(524288))) begin
            return 20'sh80000;
        end
        return v[19:0];
    endfunction

endpackage

>>> design/vertex_project_to_screen.sv
// Pipeline: products, sums, divider load, 49 one-bit divider stages,
//   normalise, scale, output register.
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds while the output register is full and not taken.
// Reset: synchronous, active low; clears all stage valid bits and restores
//   the identity matrix and a 640 x 480 framebuffer.
module vertex_project_to_screen
    import vpts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // Configuration registers
    logic [63:0] r_row [0:3];
    logic [12:0] r_wd, r_ht;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW0_RESET;
            r_row[1] <= ROW1_RESET;
            r_row[2] <= ROW2_RESET;
            r_row[3] <= ROW3_RESET;
            r_wd     <= WIDTH_RESET;
            r_ht     <= HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROW0:   r_row[0] <= i_cfg_data;
                REG_ROW1:   r_row[1] <= i_cfg_data;
                REG_ROW2:   r_row[2] <= i_cfg_data;
                REG_ROW3:   r_row[3] <= i_cfg_data;
                REG_WIDTH:  r_wd     <= i_cfg_data[12:0];
                REG_HEIGHT: r_ht     <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Global advance: every stage moves when the output slot is free or taken
    logic w_en;
    logic r_out_vld;
    t_out r_out;

    assign w_en        = !r_out_vld || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Stage A: twelve 16x16 products, the w = 1 column is a shift
    logic                   r_a_vld;
    logic signed [AccW-1:0] r_prod [0:3][0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 4; r++) begin
                r_prod[r][0] <= AccW'($signed(r_row[r][15:0]) * i_in_data.vert_x);
                r_prod[r][1] <= AccW'($signed(r_row[r][31:16]) * i_in_data.vert_y);
                r_prod[r][2] <= AccW'($signed(r_row[r][47:32]) * i_in_data.vert_z);
                r_prod[r][3] <= AccW'($signed({r_row[r][63:48], 8'h00}));
            end
        end
    end

    // Stage B: row sums in Q.20
    logic  r_b_vld;
    t_side r_b;
    logic signed [AccW-1:0] w_sum [0:3];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            w_sum[r] = r_prod[r][0] + r_prod[r][1] + r_prod[r][2] + r_prod[r][3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b.ax  <= w_sum[0];
            r_b.ay  <= w_sum[1];
            r_b.az  <= w_sum[2];
            r_b.aw  <= w_sum[3];
            r_b.div <= (w_sum[3] > 0);
        end
    end

    // Divider: stage 0 loads magnitudes, stages 1..NumW retire one bit each
    logic              r_d_vld  [0:NumW];
    t_side             r_d_side [0:NumW];
    logic [MagW-1:0]   r_d_den  [0:NumW];
    logic [MagW-1:0]   r_d_rem  [0:NumW][0:2];
    logic [NumW-1:0]   r_d_nq   [0:NumW][0:2];
    logic signed [AccW-1:0] w_a [0:2];
    logic signed [AccW-1:0] w_mag [0:2];

    assign w_a[0] = r_b.ax;
    assign w_a[1] = r_b.ay;
    assign w_a[2] = r_b.az;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_mag[c] = w_a[c][AccW-1] ? -w_a[c] : w_a[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_d_vld[0] <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_side[0] <= r_b;
            r_d_den[0]  <= r_b.div ? r_b.aw[MagW-1:0] : MagW'(1);
            for (int c = 0; c < 3; c++) begin
                r_d_rem[0][c] <= '0;
                r_d_nq[0][c]  <= {w_mag[c][MagW-1:0], 16'h0000};
            end
        end
    end

    for (genvar k = 1; k <= NumW; k++) begin : g_div
        logic [MagW:0]   w_rr  [0:2];
        logic [MagW-1:0] n_rem [0:2];
        logic [NumW-1:0] n_nq  [0:2];

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                w_rr[c] = {r_d_rem[k-1][c], r_d_nq[k-1][c][NumW-1]};
                if (w_rr[c] >= {1'b0, r_d_den[k-1]}) begin
                    n_rem[c] = MagW'(w_rr[c] - {1'b0, r_d_den[k-1]});
                    n_nq[c]  = {r_d_nq[k-1][c][NumW-2:0], 1'b1};
                end else begin
                    n_rem[c] = w_rr[c][MagW-1:0];
                    n_nq[c]  = {r_d_nq[k-1][c][NumW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_d_vld[k] <= r_d_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d_side[k] <= r_d_side[k-1];
                r_d_den[k]  <= r_d_den[k-1];
                r_d_rem[k]  <= n_rem;
                r_d_nq[k]   <= n_nq;
            end
        end
    end

    // Stage P1: signed quotient or floor shift, clamp x and y, depth and w
    t_side r_e_side_q;
    logic  r_e_vld;
    logic signed [NdcW-1:0] r_nx, r_nny;
    logic signed [15:0]     r_dz;
    logic signed [31:0]     r_cw;
    logic                   r_e_div;
    logic signed [NumW:0]   w_n [0:2];
    logic signed [NumW:0]   w_nyneg;
    logic signed [NumW:0]   w_dz;
    logic signed [AccW-1:0] w_cw;
    localparam logic signed [NumW:0] NdcMax = (NumW+1)'(64'sd1 <<< 33);

    assign r_e_side_q = r_d_side[NumW];

    function automatic logic w_a_sign(input int c);
        case (c)
            0:       return r_e_side_q.ax[AccW-1];
            1:       return r_e_side_q.ay[AccW-1];
            default: return r_e_side_q.az[AccW-1];
        endcase
    endfunction

    function automatic logic signed [AccW-1:0] w_raw(input int c);
        case (c)
            0:       return r_e_side_q.ax;
            1:       return r_e_side_q.ay;
            default: return r_e_side_q.az;
        endcase
    endfunction

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (r_e_side_q.div) begin
                w_n[c] = w_a_sign(c) ? -$signed({1'b0, r_d_nq[NumW][c]})
                                     : $signed({1'b0, r_d_nq[NumW][c]});
            end else begin
                w_n[c] = (NumW+1)'(w_raw(c) >>> 4);
            end
            if (c < 2) begin
                if (w_n[c] > NdcMax) begin
                    w_n[c] = NdcMax;
                end else if (w_n[c] < -NdcMax) begin
                    w_n[c] = -NdcMax;
                end
            end
        end
        w_nyneg = -w_n[1];
        w_dz    = w_n[2] >>> 4;
        w_cw    = r_e_side_q.aw >>> 4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= r_d_vld[NumW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx    <= w_n[0][NdcW-1:0];
            r_nny   <= w_nyneg[NdcW-1:0];
            if (w_dz > $signed((NumW+1)'(32767))) begin
                r_dz <= 16'sh7FFF;
            end else if (w_dz < -$signed((NumW+1)'(32768))) begin
                r_dz <= 16'sh8000;
            end else begin
                r_dz <= w_dz[15:0];
            end
            if (w_cw > $signed(AccW'(64'sd2147483647))) begin
                r_cw <= 32'sh7FFF_FFFF;
            end else if (w_cw < -$signed(AccW'(64'sd2147483648))) begin
                r_cw <= 32'sh8000_0000;
            end else begin
                r_cw <= w_cw[31:0];
            end
            r_e_div <= r_e_side_q.div;
        end
    end

    // Stage P2: scale by framebuffer size
    logic                    r_f_vld;
    logic signed [ProdW-1:0] r_px, r_py;
    logic signed [15:0]      r_f_dz;
    logic signed [31:0]      r_f_cw;
    logic                    r_f_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px    <= ProdW'(r_nx * $signed({1'b0, r_wd}));
            r_py    <= ProdW'(r_nny * $signed({1'b0, r_ht}));
            r_f_dz  <= r_dz;
            r_f_cw  <= r_cw;
            r_f_div <= r_e_div;
        end
    end

    // Stage P3: floor to Q16.4, add the centre, saturate, hold for output
    logic signed [ProdW:0] w_sx, w_sy;

    always_comb begin
        w_sx = (ProdW+1)'(r_px >>> 13) + $signed({(ProdW-15)'(0), r_wd, 3'b000});
        w_sy = (ProdW+1)'(r_py >>> 13) + $signed({(ProdW-15)'(0), r_ht, 3'b000});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.screen_x <= sat20(w_sx);
            r_out.screen_y <= sat20(w_sy);
            r_out.depth_z  <= r_f_dz;
            r_out.clip_w   <= r_f_cw;
            r_out.divided  <= r_f_div;
        end
    end

`ifndef ASSERT_OFF
    a_div_w_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divided |-> !o_out_data.clip_w[31])
        else $error("divided result with negative w");

    a_nodiv_w_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.divided |->
            (o_out_data.clip_w[31] || o_out_data.clip_w == 32'sd0))
        else $error("undivided result with positive w");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid straight after reset");

    a_stall_holds_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item taken while pipeline stalled");
`endif

endmodule

>>> tb/tb_vertex_project_to_screen.sv
`timescale 1ns / 1ps

module tb_vertex_project_to_screen;
    import vpts_pkg::*;

    localparam int unsigned LATENCY    = 55;
    localparam int unsigned STALL_LIM  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // Local copy of the register file, updated as each write is taken
    logic [63:0] mat_row [4];
    logic [12:0] fb_w;
    logic [12:0] fb_h;

    t_out        pending_vertices [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off = 0;

    vertex_project_to_screen dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Floor shift right for signed 64-bit values
    function automatic longint floor_shr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint dot_row(input logic [63:0] row, input t_in v);
        longint c0, c1, c2, c3;
        c0 = longint'($signed(row[15:0]));
        c1 = longint'($signed(row[31:16]));
        c2 = longint'($signed(row[47:32]));
        c3 = longint'($signed(row[63:48]));
        return c0 * longint'(v.vert_x) + c1 * longint'(v.vert_y) +
               c2 * longint'(v.vert_z) + c3 * 256;
    endfunction

    // Divide to Q.16 truncating toward zero, or floor-shift Q.20 down to Q.16
    function automatic longint to_ndc(input longint a, input longint w, input bit do_div);
        if (do_div) return (a * 65536) / w;
        return floor_shr(a, 4);
    endfunction

    function automatic t_out project_vertex(input t_in v);
        t_out   r;
        longint ax, ay, az, aw, nx, ny, nz, wd, ht;
        bit     do_div;
        ax = dot_row(mat_row[0], v);
        ay = dot_row(mat_row[1], v);
        az = dot_row(mat_row[2], v);
        aw = dot_row(mat_row[3], v);
        do_div = aw > 0;
        nx = clamp(to_ndc(ax, aw, do_div), -(64'sd1 <<< 40), 64'sd1 <<< 40);
        ny = clamp(to_ndc(ay, aw, do_div), -(64'sd1 <<< 40), 64'sd1 <<< 40);
        nz = to_ndc(az, aw, do_div);
        wd = longint'(fb_w);
        ht = longint'(fb_h);
        r.screen_x = 20'(clamp(floor_shr(nx * wd, 13) + wd * 8, -524288, 524287));
        r.screen_y = 20'(clamp(floor_shr(-ny * ht, 13) + ht * 8, -524288, 524287));
        r.depth_z  = 16'(clamp(floor_shr(nz, 4), -32768, 32767));
        r.clip_w   = 32'(clamp(floor_shr(aw, 4), -64'sd2147483648, 64'sd2147483647));
        r.divided  = do_div;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    // Sample results at the rising edge; predict at input accept
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                pending_vertices.push_back(project_vertex(i_in_data));
            if (o_out_valid && i_out_ready) begin
                if (pending_vertices.size() == 0) begin
                    report_mismatch("unexpected item", 0, 0);
                end else begin
                    want = pending_vertices.pop_front();
                    if (o_out_data.screen_x !== want.screen_x)
                        report_mismatch("screen_x", o_out_data.screen_x, want.screen_x);
                    if (o_out_data.screen_y !== want.screen_y)
                        report_mismatch("screen_y", o_out_data.screen_y, want.screen_y);
                    if (o_out_data.depth_z !== want.depth_z)
                        report_mismatch("depth_z", o_out_data.depth_z, want.depth_z);
                    if (o_out_data.clip_w !== want.clip_w)
                        report_mismatch("clip_w", o_out_data.clip_w, want.clip_w);
                    if (o_out_data.divided !== want.divided)
                        report_mismatch("divided", o_out_data.divided, want.divided);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROW0:   mat_row[0] <= i_cfg_data;
                    REG_ROW1:   mat_row[1] <= i_cfg_data;
                    REG_ROW2:   mat_row[2] <= i_cfg_data;
                    REG_ROW3:   mat_row[3] <= i_cfg_data;
                    REG_WIDTH:  fb_w <= i_cfg_data[12:0];
                    REG_HEIGHT: fb_h <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    // Drive the receiver's ready at the falling edge; a hold-off overrides it
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off > 0) begin
            i_out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: count cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n || hold_off > 0) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIM) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Valid stays high into the next item; idle gaps and drain drop it
    task automatic send_vertex(input t_in v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        // Let a write that has just ended drop valid before the next one
        if (i_cfg_valid) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in random_vertex(input bit narrow);
        t_in v;
        v = t_in'(48'({$urandom, $urandom}));
        if (narrow) begin
            // Keep the vertex within a few units so the divide sees sane values
            v.vert_x = 16'(int'($urandom_range(2048)) - 1024);
            v.vert_y = 16'(int'($urandom_range(2048)) - 1024);
            v.vert_z = 16'(int'($urandom_range(2048)) - 1024);
        end
        return v;
    endfunction

    function automatic logic [63:0] perspective_matrix_row(input int r);
        logic [15:0] c [4];
        for (int k = 0; k < 4; k++) c[k] = 16'(int'($urandom_range(1024)) - 512);
        c[r] = 16'(int'($urandom_range(8192)) + 1024);
        // A w row that leans on z gives a real perspective divide
        if (r == 3) begin
            c[2] = 16'(int'($urandom_range(4096)));
            c[3] = 16'(int'($urandom_range(8192)));
        end
        return {c[3], c[2], c[1], c[0]};
    endfunction

    // Extremes of every field under the reset identity, then odd matrices
    task automatic test_directed();
        t_in v;
        logic [15:0] edges [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        for (int k = 0; k < 5; k++) begin
            v.vert_x = edges[k];
            v.vert_y = edges[4 - k];
            v.vert_z = edges[(k + 2) % 5];
            send_vertex(v);
        end
        drain_pipeline();
        // Negative, zero and tiny positive w; all-ones and max coefficients
        write_reg(REG_ROW3, 64'h0000_0000_0000_0000);
        send_vertex('{16'sh0100, -16'sh0100, 16'sh0200});
        drain_pipeline();
        write_reg(REG_ROW3, 64'h0001_0000_0000_0000);
        send_vertex('{16'sh7FFF, 16'sh8000, 16'sh7FFF});
        drain_pipeline();
        write_reg(REG_ROW3, 64'h8000_0000_0000_0000);
        send_vertex('{16'sh0100, 16'sh0100, 16'sh0100});
        drain_pipeline();
        write_reg(REG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_ROW1, 64'h8000_8000_8000_8000);
        write_reg(REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_ROW3, 64'h7FFF_0001_0000_0000);
        write_reg(REG_WIDTH, 64'd4096);
        write_reg(REG_HEIGHT, 64'd1);
        send_vertex('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_vertex('{16'sh8000, 16'sh8000, 16'sh8000});
        send_vertex('{16'sh8000, 16'sh7FFF, -16'sh0001});
        drain_pipeline();
        // Full 13-bit sizes and a zero size
        write_reg(REG_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_HEIGHT, 64'd0);
        send_vertex('{16'sh0040, 16'sh0040, 16'sh0040});
        send_vertex('{-16'sh0040, 16'sh7FFF, 16'sh0001});
        drain_pipeline();
    endtask

    // Random phases under a fresh configuration each time
    task automatic test_random(input int n_items, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int p = 0; p < 4; p++) begin
            for (int r = 0; r < 4; r++) begin
                if ($urandom_range(4) == 0)
                    write_reg(3'(r), {$urandom, $urandom});
                else
                    write_reg(3'(r), perspective_matrix_row(r));
            end
            write_reg(REG_WIDTH, 64'($urandom_range(4096, 1)));
            write_reg(REG_HEIGHT, ($urandom_range(7) == 0) ? {$urandom, $urandom}
                                                             : 64'($urandom_range(2048, 1)));
            for (int k = 0; k < n_items / 4; k++)
                send_vertex(random_vertex($urandom_range(9) < 7));
            drain_pipeline();
        end
    endtask

    // Stall the receiver while the sender keeps offering, so input backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge i_clk);
        hold_off = 300;
        for (int k = 0; k < 150; k++) send_vertex(random_vertex(1'b1));
        drain_pipeline();
    endtask

    initial begin
        mat_row[0] = ROW0_RESET;
        mat_row[1] = ROW1_RESET;
        mat_row[2] = ROW2_RESET;
        mat_row[3] = ROW3_RESET;
        fb_w = WIDTH_RESET;
        fb_h = HEIGHT_RESET;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(640, 28, 57);
        test_random(640, 57, 28);
        test_random(640, 0, 0);
        test_backpressure();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
design/vpts_pkg.sv
design/vertex_project_to_screen.sv
tb/tb_vertex_project_to_screen.sv
